/* src/tmcg_pkg.sv */
package tmcg_pkg;

	// default geometry
	localparam int VRAM_BYTES_DEF  = 2048;
	localparam int GLYPH_LINES_DEF = 16;
	localparam int FONT_BYTES_DEF  = 2048;

	// fixed field widths
	localparam int FUNC_W  = 2;
	localparam int ADDR_W  = 11;
	localparam int DATA_W  = 8;
	localparam int ROW_W   = 7;
	localparam int LINE_W  = 4;
	localparam int COL_W   = 8;
	localparam int LPR_W   = 5;
	localparam int CLINE_W = 16;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 3;

	// item kinds
	localparam logic [FUNC_W-1:0] FUNC_RENDER = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_VRAM   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_GLYPH  = 2'd2;

	// character RAM fill value after reset
	localparam logic [DATA_W-1:0] VRAM_FILL = 8'hFF;

	// register reset values
	localparam logic [COL_W-1:0] COLUMNS_RST = 8'd80;
	localparam logic [ROW_W-1:0] ROWS_RST    = 7'd24;
	localparam logic [LPR_W-1:0] LPR_RST     = 5'd8;

	typedef enum logic [CIDX_W-1:0] {
		REG_COLUMNS       = 3'd0,
		REG_ROWS          = 3'd1,
		REG_LINES_PER_ROW = 3'd2,
		REG_START_ADDRESS = 3'd3,
		REG_CURSOR_ROW    = 3'd4,
		REG_CURSOR_COL    = 3'd5,
		REG_CURSOR_LINES  = 3'd6,
		REG_DISPLAY_ON    = 3'd7
	} cfg_idx_t;

	// per-beat control carried through the render pipeline
	typedef struct packed {
		logic              valid;
		logic              visible;
		logic              cursor;
		logic [LINE_W-1:0] line;
	} rnd_ctl_t;

endpackage

/* src/tmcg_char_ram.sv */
module tmcg_char_ram #(
	parameter int VRAM_BYTES = tmcg_pkg::VRAM_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [$clog2(VRAM_BYTES)-1:0] wr_addr,
	input  logic [tmcg_pkg::DATA_W-1:0]   wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(VRAM_BYTES)-1:0] rd_addr,
	output logic [tmcg_pkg::DATA_W-1:0]   rd_data,
	output logic                          busy
);
	import tmcg_pkg::*;

	localparam int VA = $clog2(VRAM_BYTES);

	logic [DATA_W-1:0] mem [VRAM_BYTES];
	logic [VA:0]       clr_q;     // top bit set once the fill pass is done
	logic              we;
	logic [VA-1:0]     wa;
	logic [DATA_W-1:0] wd;

	assign busy = !clr_q[VA];
	assign we   = busy || wr_en;
	assign wa   = busy ? clr_q[VA-1:0] : wr_addr;
	assign wd   = busy ? VRAM_FILL : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (we) begin
			mem[wa] <= wd;
		end
	end

endmodule

/* src/tmcg_glyph_ram.sv */
module tmcg_glyph_ram #(
	parameter int FONT_BYTES = tmcg_pkg::FONT_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(FONT_BYTES)-1:0] wr_addr,
	input  logic [tmcg_pkg::DATA_W-1:0]   wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(FONT_BYTES)-1:0] rd_addr,
	output logic [tmcg_pkg::DATA_W-1:0]   rd_data
);
	import tmcg_pkg::*;

	// only the normal half is stored; the inverse half is derived on read
	logic [DATA_W-1:0] mem [FONT_BYTES];

	// read-first: a load in the same cycle lands after the older render's read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

/* src/tmcg_out_buf.sv */
module tmcg_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [tmcg_pkg::DATA_W-1:0] push_data,
	output logic                        full,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tmcg_pkg::DATA_W-1:0] pixels
);
	import tmcg_pkg::*;

	logic [DATA_W-1:0] ent_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign pixels    = ent_q[rd_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

/* src/text_mode_char_generator.sv */
// Text-mode character generator.
// Input channel (in_valid / in_stall) carries one beat per item: func selects
// a render request, a character RAM write or a glyph byte load. Only renders
// produce a beat on the output channel (out_valid / out_stall, pixels).
// Configuration registers are written through cfg_valid / cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high and writes take effect
// at the next edge. Change them only while no render is in flight.
// Throughput: one item per cycle while in_stall is low. The pipeline is char
// RAM read, then glyph RAM read, then the pixel byte into a two-entry output
// buffer; a render's pixels show once its byte is in that buffer.
// Receiver stall: the output buffer absorbs the beat in flight; while it is
// full the pipeline freezes and in_stall is raised.
// Reset: registers take their defaults, then a fill pass writes 0xFF to
// every character RAM entry, one per cycle; in_stall stays high
// during the pass.
module text_mode_char_generator #(
	parameter int VRAM_BYTES  = tmcg_pkg::VRAM_BYTES_DEF,
	parameter int GLYPH_LINES = tmcg_pkg::GLYPH_LINES_DEF,
	parameter int FONT_BYTES  = tmcg_pkg::FONT_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tmcg_pkg::FUNC_W-1:0] func,
	input  logic [tmcg_pkg::ADDR_W-1:0] mem_addr,
	input  logic [tmcg_pkg::DATA_W-1:0] data,
	input  logic [tmcg_pkg::ROW_W-1:0]  text_row,
	input  logic [tmcg_pkg::LINE_W-1:0] scan_line,
	input  logic [tmcg_pkg::COL_W-1:0]  text_col,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tmcg_pkg::DATA_W-1:0] pixels,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  tmcg_pkg::cfg_idx_t          cfg_index,
	input  logic [tmcg_pkg::CFG_W-1:0]  cfg_data
);
	import tmcg_pkg::*;

	localparam int VA    = $clog2(VRAM_BYTES);
	localparam int FA    = $clog2(FONT_BYTES);
	localparam int GLW   = $clog2(GLYPH_LINES);
	localparam int MVW   = (VA > ADDR_W) ? VA : ADDR_W;
	localparam int MFW   = (FA > ADDR_W) ? FA : ADDR_W;
	localparam int SUM_W = ROW_W + COL_W + 2;              // start + row*cols + col
	localparam int SVW   = (VA > SUM_W) ? VA : SUM_W;
	localparam int GIW0  = DATA_W + GLW + 1;
	localparam int GIW   = (GIW0 > FA + 1) ? GIW0 : FA + 1;

	// configuration
	logic [COL_W-1:0]   columns_q;
	logic [ROW_W-1:0]   rows_q;
	logic [LPR_W-1:0]   lpr_q;
	logic [ADDR_W-1:0]  start_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [CLINE_W-1:0] cur_lines_q;
	logic               disp_on_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q   <= COLUMNS_RST;
			rows_q      <= ROWS_RST;
			lpr_q       <= LPR_RST;
			start_q     <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cur_lines_q <= '0;
			disp_on_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COLUMNS:       columns_q   <= cfg_data[COL_W-1:0];
				REG_ROWS:          rows_q      <= cfg_data[ROW_W-1:0];
				REG_LINES_PER_ROW: lpr_q       <= cfg_data[LPR_W-1:0];
				REG_START_ADDRESS: start_q     <= cfg_data[ADDR_W-1:0];
				REG_CURSOR_ROW:    cur_row_q   <= cfg_data[ROW_W-1:0];
				REG_CURSOR_COL:    cur_col_q   <= cfg_data[COL_W-1:0];
				REG_CURSOR_LINES:  cur_lines_q <= cfg_data;
				REG_DISPLAY_ON:    disp_on_q   <= cfg_data[0];
			endcase
		end
	end

	// pipeline advance: frozen only while the output buffer is full
	logic buf_full;
	logic clr_busy;
	logic adv;
	logic in_acc;

	assign adv      = !buf_full;
	assign in_stall = clr_busy || buf_full;
	assign in_acc   = in_valid && !in_stall;

	// stage 0: address math, area and cursor checks
	logic [ROW_W+COL_W-1:0] prod;
	logic [SUM_W-1:0]       vsum;
	logic [SVW-1:0]         vsum_x;
	logic [VA-1:0]          vaddr;
	logic [MVW-1:0]         vwa_x;
	logic [MFW-1:0]         gwa_x;
	logic [DATA_W-1:0]      rev;
	rnd_ctl_t               ctl_s0;

	assign prod   = (ROW_W+COL_W)'(text_row) * (ROW_W+COL_W)'(columns_q);
	assign vsum   = SUM_W'(start_q) + SUM_W'(prod) + SUM_W'(text_col);
	assign vsum_x = SVW'(vsum);
	assign vaddr  = vsum_x[VA-1:0];
	assign vwa_x  = MVW'(mem_addr);
	assign gwa_x  = MFW'(mem_addr);

	always_comb begin
		for (int i = 0; i < DATA_W; i++) begin
			rev[i] = data[DATA_W-1-i];
		end
	end

	always_comb begin
		ctl_s0.valid   = in_acc && (func == FUNC_RENDER);
		ctl_s0.visible = disp_on_q && (text_row < rows_q) && (text_col < columns_q)
		                 && (LPR_W'(scan_line) < lpr_q);
		ctl_s0.cursor  = (text_row == cur_row_q) && (text_col == cur_col_q)
		                 && cur_lines_q[scan_line];
		ctl_s0.line    = scan_line;
	end

	logic [DATA_W-1:0] char_rd;

	tmcg_char_ram #(
		.VRAM_BYTES(VRAM_BYTES)
	) u_char_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (in_acc && (func == FUNC_VRAM)),
		.wr_addr(vwa_x[VA-1:0]),
		.wr_data(data),
		.rd_en  (adv),
		.rd_addr(vaddr),
		.rd_data(char_rd),
		.busy   (clr_busy)
	);

	// stage 1: glyph index from the character code
	rnd_ctl_t       ctl_s1;
	logic [GIW-1:0] gidx;
	logic           hi_s2;
	rnd_ctl_t       ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
		end
	end

	assign gidx = (GIW'(char_rd) << GLW) + GIW'(ctl_s1.line);

	// upper half of the glyph space is the inverse of the lower half
	always_ff @(posedge clk) begin
		if (adv) begin
			hi_s2 <= gidx[FA];
		end
	end

	logic [DATA_W-1:0] glyph_rd;

	tmcg_glyph_ram #(
		.FONT_BYTES(FONT_BYTES)
	) u_glyph_ram (
		.clk    (clk),
		.wr_en  (in_acc && (func == FUNC_GLYPH)),
		.wr_addr(gwa_x[FA-1:0]),
		.wr_data(rev),
		.rd_en  (adv),
		.rd_addr(gidx[FA-1:0]),
		.rd_data(glyph_rd)
	);

	// stage 2: inversion and blanking
	logic [DATA_W-1:0] pix_s2;

	assign pix_s2 = ctl_s2.visible ? (glyph_rd ^ {DATA_W{hi_s2 ^ ctl_s2.cursor}}) : '0;

	tmcg_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv && ctl_s2.valid),
		.push_data(pix_s2),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixels   (pixels)
	);

endmodule
